### rtl/ctlex_pkg.sv
// ----------------------------------------------------------------------------
// ctlex_pkg
// Shared types and constants for the configuration text lexer: token codes,
// lexer modes, the result record and the queue entry between front and back.
// ----------------------------------------------------------------------------
package ctlex_pkg;

    // Token type codes as they appear on the result channel
    typedef enum logic [3:0] {
        TT_ID      = 4'd0,
        TT_STR     = 4'd1,
        TT_INT     = 4'd2,
        TT_LBRACE  = 4'd3,
        TT_RBRACE  = 4'd4,
        TT_EQUALS  = 4'd5,
        TT_SEMI    = 4'd6,
        TT_SECTION = 4'd7,
        TT_EOF     = 4'd8,
        TT_ERROR   = 4'd9
    } t_tok_type;

    // Lexer modes, one-hot
    typedef enum logic [8:0] {
        M_INIT    = 9'b000000001,
        M_ID      = 9'b000000010,
        M_STRCONT = 9'b000000100,
        M_STRESC  = 9'b000001000,
        M_STR     = 9'b000010000,
        M_NEG     = 9'b000100000,
        M_INT     = 9'b001000000,
        M_WS      = 9'b010000000,
        M_COM     = 9'b100000000
    } t_mode;

    // One result record
    typedef struct packed {
        t_tok_type   tok;
        logic [15:0] start;
        logic [15:0] raw;
        logic [15:0] value;
        logic [16:0] epos;
    } t_result;

    // Results caused by one input item: one or two records
    typedef struct packed {
        t_result r0;
        t_result r1;
        logic    two;
    } t_entry;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

endpackage

### rtl/ctlex_front.sv
// ----------------------------------------------------------------------------
// ctlex_front
// Accepts one byte or end marker per cycle while the queue has room, runs the
// lexer FSM and pushes the one or two result records it causes into the queue.
// ----------------------------------------------------------------------------
module ctlex_front
    import ctlex_pkg::*;
#(
    parameter int MAX_INPUT_BYTES = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_text_byte,
    input  logic        i_q_ready,
    output logic        o_push,
    output t_entry      o_entry
);

    localparam int               PW       = $clog2(MAX_INPUT_BYTES + 1);
    localparam logic [PW-1:0]    MAX_POS  = PW'(MAX_INPUT_BYTES);
    localparam logic [16:0]      OVF_EPOS = 17'(MAX_INPUT_BYTES + 1);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // Letters of the keyword "section"
    function automatic logic [7:0] kw_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h73;
            3'd1:    ch = 8'h65;
            3'd2:    ch = 8'h63;
            3'd3:    ch = 8'h74;
            3'd4:    ch = 8'h69;
            3'd5:    ch = 8'h6F;
            3'd6:    ch = 8'h6E;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic t_result mk_tok(input t_tok_type tok, input logic [15:0] start,
                                       input logic [15:0] raw);
        t_result r;
        r.tok   = tok;
        r.start = start;
        r.raw   = raw;
        r.value = raw;
        r.epos  = '0;
        return r;
    endfunction

    function automatic t_result mk_err(input logic [16:0] epos);
        t_result r;
        r       = '0;
        r.tok   = TT_ERROR;
        r.epos  = epos;
        return r;
    endfunction

    t_mode         r_mode,    n_mode;
    logic [PW-1:0] r_pos,     n_pos;
    logic [15:0]   r_tstart,  n_tstart;
    logic [15:0]   r_ucnt,    n_ucnt;
    logic [2:0]    r_kw_prog, n_kw_prog;
    logic          r_kw_mm,   n_kw_mm;
    logic          r_failed,  n_failed;

    logic          accept;
    logic [7:0]    c;
    logic          is_alpha, is_digit, is_space, is_crlf;
    logic [15:0]   pos16, len;
    logic [16:0]   pos_p1;
    t_result       ident_res, str_res, res_a, res_l;
    logic          emit_a, emit_l, reopen, fail, bad;

    assign accept     = i_in_valid && i_q_ready;
    assign o_in_ready = i_q_ready;

    // Classify the byte
    assign c        = i_text_byte;
    assign is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    assign is_digit = (c >= CH_ZERO && c <= CH_NINE);
    assign is_crlf  = (c == CH_CR) || (c == CH_LF);
    assign is_space = (c == CH_SPACE) || (c == CH_TAB) || is_crlf;

    assign pos16  = 16'(r_pos);
    assign len    = pos16 - r_tstart;
    assign pos_p1 = 17'({1'b0, r_pos} + 1'b1);

    // Records for tokens closed at the current position
    always_comb begin
        ident_res = mk_tok((!r_kw_mm && r_kw_prog == 3'd7) ? TT_SECTION : TT_ID,
                           r_tstart, len);
        str_res       = mk_tok(TT_STR, r_tstart, len);
        str_res.value = r_ucnt;
    end

    // Lexer next state and results
    always_comb begin
        n_mode    = r_mode;
        n_pos     = r_pos;
        n_tstart  = r_tstart;
        n_ucnt    = r_ucnt;
        n_kw_prog = r_kw_prog;
        n_kw_mm   = r_kw_mm;
        n_failed  = r_failed;
        res_a     = '0;
        res_l     = '0;
        emit_a    = 1'b0;
        emit_l    = 1'b0;
        reopen    = 1'b0;
        fail      = 1'b0;
        bad       = 1'b0;

        if (i_kind) begin
            // End marker: unless failed, flush the open token, then eof or error
            if (!r_failed) begin
                unique case (r_mode)
                    M_ID: begin
                        res_a  = ident_res;
                        emit_a = 1'b1;
                    end
                    M_STR: begin
                        res_a  = str_res;
                        emit_a = 1'b1;
                    end
                    M_INT: begin
                        res_a  = mk_tok(TT_INT, r_tstart, len);
                        emit_a = 1'b1;
                    end
                    M_STRCONT, M_STRESC, M_NEG: bad = 1'b1;
                    default: ;
                endcase
                emit_l = 1'b1;
                res_l  = bad ? mk_err(pos_p1) : mk_tok(TT_EOF, pos16, 16'd0);
            end
            n_mode    = M_INIT;
            n_pos     = '0;
            n_tstart  = '0;
            n_ucnt    = '0;
            n_kw_prog = '0;
            n_kw_mm   = 1'b0;
            n_failed  = 1'b0;
        end else if (!r_failed) begin
            if (r_pos >= MAX_POS) begin
                // Input too long
                emit_l   = 1'b1;
                res_l    = mk_err(OVF_EPOS);
                n_failed = 1'b1;
            end else begin
                // Continue the current mode
                unique case (r_mode)
                    M_ID: begin
                        if (is_alpha || is_digit) begin
                            if (!r_kw_mm && r_kw_prog != 3'd7 && c == kw_char(r_kw_prog)) begin
                                n_kw_prog = r_kw_prog + 3'd1;
                            end else begin
                                n_kw_mm = 1'b1;
                            end
                        end else begin
                            res_a  = ident_res;
                            emit_a = 1'b1;
                            reopen = 1'b1;
                        end
                    end
                    M_STRCONT: begin
                        if (c == CH_BSLASH) begin
                            n_mode = M_STRESC;
                        end else if (c == CH_QUOTE) begin
                            n_mode = M_STR;
                        end else begin
                            n_ucnt = r_ucnt + 16'd1;
                        end
                    end
                    M_STRESC: begin
                        if (c == CH_BSLASH || c == CH_QUOTE) begin
                            n_ucnt = r_ucnt + 16'd1;
                            n_mode = M_STRCONT;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                    M_STR: begin
                        res_a  = str_res;
                        emit_a = 1'b1;
                        reopen = 1'b1;
                    end
                    M_NEG: begin
                        if (is_digit && c != CH_ZERO) begin
                            n_mode = M_INT;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                    M_INT: begin
                        if (!is_digit) begin
                            res_a  = mk_tok(TT_INT, r_tstart, len);
                            emit_a = 1'b1;
                            reopen = 1'b1;
                        end
                    end
                    M_WS: begin
                        if (!is_space) begin
                            reopen = 1'b1;
                        end
                    end
                    M_COM: begin
                        if (is_crlf) begin
                            n_mode = M_INIT;
                        end
                    end
                    default: reopen = 1'b1;
                endcase

                // Lex the byte afresh from the initial mode
                if (reopen) begin
                    n_mode   = M_INIT;
                    n_tstart = pos16;
                    if (is_alpha) begin
                        n_mode    = M_ID;
                        n_kw_prog = (c == kw_char(3'd0)) ? 3'd1 : 3'd0;
                        n_kw_mm   = (c != kw_char(3'd0));
                    end else if (c == CH_QUOTE) begin
                        n_mode = M_STRCONT;
                        n_ucnt = '0;
                    end else if (c == CH_ZERO) begin
                        res_l  = mk_tok(TT_INT, pos16, 16'd1);
                        emit_l = 1'b1;
                    end else if (is_digit) begin
                        n_mode = M_INT;
                    end else if (c == CH_MINUS) begin
                        n_mode = M_NEG;
                    end else if (c == CH_LBRACE) begin
                        res_l  = mk_tok(TT_LBRACE, pos16, 16'd1);
                        emit_l = 1'b1;
                    end else if (c == CH_RBRACE) begin
                        res_l  = mk_tok(TT_RBRACE, pos16, 16'd1);
                        emit_l = 1'b1;
                    end else if (c == CH_EQUALS) begin
                        res_l  = mk_tok(TT_EQUALS, pos16, 16'd1);
                        emit_l = 1'b1;
                    end else if (c == CH_SEMI) begin
                        res_l  = mk_tok(TT_SEMI, pos16, 16'd1);
                        emit_l = 1'b1;
                    end else if (is_space) begin
                        n_mode = M_WS;
                    end else if (c == CH_HASH) begin
                        n_mode = M_COM;
                    end else begin
                        fail = 1'b1;
                    end
                end

                // Illegal byte: report once, then ignore until the end marker
                if (fail) begin
                    res_l    = mk_err(pos_p1);
                    emit_l   = 1'b1;
                    n_failed = 1'b1;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
        end
    end

    // Pack the results of this item
    always_comb begin
        o_entry.r0  = emit_a ? res_a : res_l;
        o_entry.r1  = res_l;
        o_entry.two = emit_a && emit_l;
        o_push      = accept && (emit_a || emit_l);
    end

    // Advance lexer state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_INIT;
            r_pos     <= '0;
            r_tstart  <= '0;
            r_ucnt    <= '0;
            r_kw_prog <= '0;
            r_kw_mm   <= 1'b0;
            r_failed  <= 1'b0;
        end else if (accept) begin
            r_mode    <= n_mode;
            r_pos     <= n_pos;
            r_tstart  <= n_tstart;
            r_ucnt    <= n_ucnt;
            r_kw_prog <= n_kw_prog;
            r_kw_mm   <= n_kw_mm;
            r_failed  <= n_failed;
        end
    end

endmodule

### rtl/ctlex_queue.sv
// ----------------------------------------------------------------------------
// ctlex_queue
// Short FIFO of result entries between the lexer front and the output back.
// ----------------------------------------------------------------------------
module ctlex_queue
    import ctlex_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_ready,
    output logic   o_valid,
    output t_entry o_entry,
    input  logic   i_pop
);

    t_entry               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wptr, n_wptr;
    logic [QUEUE_AW-1:0]  r_rptr, n_rptr;
    logic [QUEUE_AW:0]    r_count, n_count;
    logic                 do_push, do_pop;

    assign o_ready = (r_count != QUEUE_AW'(0) + (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rptr];

    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Move pointers and fill count
    always_comb begin
        n_wptr  = do_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = do_pop  ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

endmodule

### rtl/ctlex_back.sv
// ----------------------------------------------------------------------------
// ctlex_back
// Splits each queue entry into its result records and drives the registered
// result channel, one record per transfer.
// ----------------------------------------------------------------------------
module ctlex_back
    import ctlex_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_head_valid,
    input  t_entry      i_head,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_token_type,
    output logic [15:0] o_start_pos,
    output logic [15:0] o_raw_length,
    output logic [15:0] o_value_length,
    output logic [16:0] o_error_pos,
    output logic        o_last
);

    logic    r_out_valid, n_out_valid;
    logic    r_sel, n_sel;
    t_result r_res;
    logic    r_last;
    logic    take, load, is_last;
    t_result cur;

    // Pick the next record of the head entry
    always_comb begin
        take        = !r_out_valid || i_out_ready;
        load        = take && i_head_valid;
        cur         = r_sel ? i_head.r1 : i_head.r0;
        is_last     = r_sel || !i_head.two;
        o_pop       = load && is_last;
        n_sel       = load ? !is_last : r_sel;
        n_out_valid = take ? i_head_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sel       <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_sel       <= n_sel;
        end
    end

    // Hold the record until it is transferred
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res  <= cur;
            r_last <= is_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_token_type   = r_res.tok;
    assign o_start_pos    = r_res.start;
    assign o_raw_length   = r_res.raw;
    assign o_value_length = r_res.value;
    assign o_error_pos    = r_res.epos;
    assign o_last         = r_last;

endmodule

### rtl/config_text_lexer_top.sv
// ----------------------------------------------------------------------------
// config_text_lexer_top
// Streaming lexer for configuration text: bytes and an end marker in, token
// records (type, offsets, lengths, error position) out.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+--------------------------------------
//   input    | i_in_valid / o_in_ready  | i_kind, i_text_byte
//   result   | o_out_valid / i_out_ready| o_token_type, o_start_pos,
//            |                          | o_raw_length, o_value_length,
//            |                          | o_error_pos, o_last
//
// One input item is taken per cycle; the lexer state updates in the cycle of
// the transfer. An item causes zero, one or two results; the result port
// delivers one per cycle unless stalled, so the sustained rate is one item per
// cycle when each item causes at most one result. A 4-entry queue separates the
// lexer from the output register; the input stalls only when that queue is full.
// Reset is synchronous and active low and needs no clearing pass.
// ----------------------------------------------------------------------------
module config_text_lexer_top
    import ctlex_pkg::*;
#(
    parameter int MAX_INPUT_BYTES = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_text_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_token_type,
    output logic [15:0] o_start_pos,
    output logic [15:0] o_raw_length,
    output logic [15:0] o_value_length,
    output logic [16:0] o_error_pos,
    output logic        o_last
);

    logic   q_ready, q_valid, push, pop;
    t_entry push_entry, head_entry;

    ctlex_front #(
        .MAX_INPUT_BYTES (MAX_INPUT_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_text_byte (i_text_byte),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    ctlex_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_entry (head_entry),
        .i_pop   (pop)
    );

    ctlex_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (q_valid),
        .i_head         (head_entry),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_token_type   (o_token_type),
        .o_start_pos    (o_start_pos),
        .o_raw_length   (o_raw_length),
        .o_value_length (o_value_length),
        .o_error_pos    (o_error_pos),
        .o_last         (o_last)
    );

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: configuration text lexer testbench
// Drives bytes and end markers into config_text_lexer_top and checks every
// token record against a lexer predictor held in the bench. A short table
// covers the token kinds and error cases, a long receiver hold-off fills the
// block, and four phases of random config text run under different idle and
// stall mixes.
// ----------------------------------------------------------------------------
module tb_top
    import ctlex_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BYTES      = 65535;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int PHASE_ITEMS    = 48;
    localparam int SETTLE_CYCLES  = 20;

    // Input item kinds
    localparam logic IT_BYTE = 1'b0;
    localparam logic IT_END  = 1'b1;

    // Characters the lexer cares about
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic [55:0] KW_SECTION = "section";

    typedef enum logic [1:0] {
        PIN_NONE,
        PIN_EOF,
        PIN_ERR
    } t_pin;

    typedef struct packed {
        t_tok_type   tok;
        logic [15:0] start;
        logic [15:0] raw;
        logic [15:0] value;
        logic [16:0] epos;
        logic        last;
    } t_token_rec;

    typedef struct packed {
        logic        kind;
        logic [7:0]  ch;
        t_pin        pin;
        logic [16:0] pin_val;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_kind;
    logic [7:0]  i_text_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [3:0]  o_token_type;
    logic [15:0] o_start_pos;
    logic [15:0] o_raw_length;
    logic [15:0] o_value_length;
    logic [16:0] o_error_pos;
    logic        o_last;

    config_text_lexer_top #(
        .MAX_INPUT_BYTES(MAX_BYTES)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_text_byte    (i_text_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_token_type   (o_token_type),
        .o_start_pos    (o_start_pos),
        .o_raw_length   (o_raw_length),
        .o_value_length (o_value_length),
        .o_error_pos    (o_error_pos),
        .o_last         (o_last)
    );

    // Directed table: one row per transfer; typed expectations on end rows
    // and error rows replace the final predicted record of that transfer.
    t_stim_row dir_rows [0:32] = '{
        '{IT_END,  8'hA5,     PIN_EOF,  17'd0},
        '{IT_BYTE, "a",       PIN_NONE, 17'd0},
        '{IT_BYTE, CH_LBRACE, PIN_NONE, 17'd0},
        '{IT_BYTE, CH_RBRACE, PIN_NONE, 17'd0},
        '{IT_BYTE, CH_EQUALS, PIN_NONE, 17'd0},
        '{IT_BYTE, CH_SEMI,   PIN_NONE, 17'd0},
        '{IT_END,  8'h00,     PIN_EOF,  17'd5},
        '{IT_BYTE, "s",       PIN_NONE, 17'd0},
        '{IT_BYTE, "e",       PIN_NONE, 17'd0},
        '{IT_BYTE, "c",       PIN_NONE, 17'd0},
        '{IT_BYTE, "t",       PIN_NONE, 17'd0},
        '{IT_BYTE, "i",       PIN_NONE, 17'd0},
        '{IT_BYTE, "o",       PIN_NONE, 17'd0},
        '{IT_BYTE, "n",       PIN_NONE, 17'd0},
        '{IT_END,  8'hFF,     PIN_EOF,  17'd7},
        '{IT_BYTE, CH_QUOTE,  PIN_NONE, 17'd0},
        '{IT_BYTE, CH_BSLASH, PIN_NONE, 17'd0},
        '{IT_BYTE, CH_QUOTE,  PIN_NONE, 17'd0},
        '{IT_BYTE, CH_QUOTE,  PIN_NONE, 17'd0},
        '{IT_BYTE, CH_MINUS,  PIN_NONE, 17'd0},
        '{IT_BYTE, "1",       PIN_NONE, 17'd0},
        '{IT_END,  8'h3C,     PIN_EOF,  17'd6},
        '{IT_BYTE, 8'h00,     PIN_ERR,  17'd1},
        '{IT_END,  8'h00,     PIN_NONE, 17'd0},
        '{IT_BYTE, CH_MINUS,  PIN_NONE, 17'd0},
        '{IT_BYTE, CH_ZERO,   PIN_ERR,  17'd2},
        '{IT_END,  8'h00,     PIN_NONE, 17'd0},
        '{IT_BYTE, CH_HASH,   PIN_NONE, 17'd0},
        '{IT_BYTE, 8'hFF,     PIN_NONE, 17'd0},
        '{IT_BYTE, CH_LF,     PIN_NONE, 17'd0},
        '{IT_BYTE, CH_QUOTE,  PIN_NONE, 17'd0},
        '{IT_BYTE, CH_BSLASH, PIN_NONE, 17'd0},
        '{IT_END,  8'h00,     PIN_ERR,  17'd6}
    };

    // Lexer predictor state
    t_mode       lx_mode;
    logic [16:0] lx_pos;
    logic [15:0] lx_start;
    logic [15:0] lx_unesc;
    logic [2:0]  lx_kw_idx;
    logic        lx_kw_miss;
    logic        lx_failed;

    t_token_rec step_tokens[$];
    t_token_rec expected_tokens[$];
    t_stim_row  pin_rows[$];

    int  tx_idle_pct;
    int  rx_stall_pct;
    bit  hold_pending;
    int  fail_count;
    int  live_items;
    int  tokens_checked;

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run limit
    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function void lex_reset();
        lx_mode    = M_INIT;
        lx_pos     = '0;
        lx_start   = '0;
        lx_unesc   = '0;
        lx_kw_idx  = '0;
        lx_kw_miss = 1'b0;
        lx_failed  = 1'b0;
    endfunction

    function void emit(t_tok_type tok, logic [15:0] start, logic [15:0] raw,
                       logic [15:0] value, logic [16:0] epos);
        step_tokens.push_back('{tok, start, raw, value, epos, 1'b0});
    endfunction

    function void emit_span(t_tok_type tok, logic [16:0] end_pos);
        logic [15:0] span;
        span = end_pos[15:0] - lx_start;
        emit(tok, lx_start, span, span, '0);
    endfunction

    // Track how far the identifier still matches the keyword
    function void kw_track(logic [7:0] c);
        if (!lx_kw_miss && lx_kw_idx < 3'd7 && c == KW_SECTION[8*(6-lx_kw_idx) +: 8])
            lx_kw_idx = lx_kw_idx + 3'd1;
        else
            lx_kw_miss = 1'b1;
    endfunction

    function void emit_ident(logic [16:0] end_pos);
        emit_span((!lx_kw_miss && lx_kw_idx == 3'd7) ? TT_SECTION : TT_ID, end_pos);
    endfunction

    // Advance the predictor by one transfer; records land in step_tokens
    function void lex_transfer(logic kind, logic [7:0] c);
        logic [16:0] p;
        logic        redo;
        logic        fail;
        logic        bad;
        step_tokens.delete();
        p = lx_pos;
        if (kind == IT_END) begin
            live_items++;
            if (!lx_failed) begin
                bad = 1'b0;
                case (lx_mode)
                    M_ID:  emit_ident(p);
                    M_STR: emit(TT_STR, lx_start, p[15:0] - lx_start, lx_unesc, '0);
                    M_INT: emit_span(TT_INT, p);
                    M_STRCONT, M_STRESC, M_NEG: bad = 1'b1;
                    default: ;
                endcase
                if (bad)
                    emit(TT_ERROR, '0, '0, '0, p + 17'd1);
                else
                    emit(TT_EOF, p[15:0], '0, '0, '0);
            end
            lex_reset();
        end else if (!lx_failed) begin
            live_items++;
            if (p >= MAX_BYTES) begin
                emit(TT_ERROR, '0, '0, '0, 17'(MAX_BYTES + 1));
                lx_failed = 1'b1;
            end else begin
                // A byte that closes a token is lexed again from the idle mode
                do begin
                    redo = 1'b0;
                    fail = 1'b0;
                    case (lx_mode)
                        M_ID: begin
                            if (is_alpha(c) || is_digit(c)) begin
                                kw_track(c);
                            end else begin
                                emit_ident(p);
                                lx_mode = M_INIT;
                                redo = 1'b1;
                            end
                        end
                        M_STRCONT: begin
                            if (c == CH_BSLASH)
                                lx_mode = M_STRESC;
                            else if (c == CH_QUOTE)
                                lx_mode = M_STR;
                            else
                                lx_unesc = lx_unesc + 16'd1;
                        end
                        M_STRESC: begin
                            if (c == CH_BSLASH || c == CH_QUOTE) begin
                                lx_unesc = lx_unesc + 16'd1;
                                lx_mode  = M_STRCONT;
                            end else begin
                                fail = 1'b1;
                            end
                        end
                        M_STR: begin
                            emit(TT_STR, lx_start, p[15:0] - lx_start, lx_unesc, '0);
                            lx_mode = M_INIT;
                            redo = 1'b1;
                        end
                        M_NEG: begin
                            if (is_digit(c) && c != CH_ZERO)
                                lx_mode = M_INT;
                            else
                                fail = 1'b1;
                        end
                        M_INT: begin
                            if (!is_digit(c)) begin
                                emit_span(TT_INT, p);
                                lx_mode = M_INIT;
                                redo = 1'b1;
                            end
                        end
                        M_WS: begin
                            if (!is_space(c)) begin
                                lx_mode = M_INIT;
                                redo = 1'b1;
                            end
                        end
                        M_COM: begin
                            if (c == CH_CR || c == CH_LF)
                                lx_mode = M_INIT;
                        end
                        default: begin
                            lx_mode  = M_INIT;
                            lx_start = p[15:0];
                            if (is_alpha(c)) begin
                                lx_mode    = M_ID;
                                lx_kw_idx  = '0;
                                lx_kw_miss = 1'b0;
                                kw_track(c);
                            end else if (c == CH_QUOTE) begin
                                lx_mode  = M_STRCONT;
                                lx_unesc = '0;
                            end else if (c == CH_ZERO) begin
                                emit(TT_INT, p[15:0], 16'd1, 16'd1, '0);
                            end else if (is_digit(c)) begin
                                lx_mode = M_INT;
                            end else if (c == CH_MINUS) begin
                                lx_mode = M_NEG;
                            end else if (c == CH_LBRACE) begin
                                emit(TT_LBRACE, p[15:0], 16'd1, 16'd1, '0);
                            end else if (c == CH_RBRACE) begin
                                emit(TT_RBRACE, p[15:0], 16'd1, 16'd1, '0);
                            end else if (c == CH_EQUALS) begin
                                emit(TT_EQUALS, p[15:0], 16'd1, 16'd1, '0);
                            end else if (c == CH_SEMI) begin
                                emit(TT_SEMI, p[15:0], 16'd1, 16'd1, '0);
                            end else if (is_space(c)) begin
                                lx_mode = M_WS;
                            end else if (c == CH_HASH) begin
                                lx_mode = M_COM;
                            end else begin
                                fail = 1'b1;
                            end
                        end
                    endcase
                    if (fail) begin
                        emit(TT_ERROR, '0, '0, '0, p + 17'd1);
                        lx_failed = 1'b1;
                    end
                end while (redo);
                if (!lx_failed)
                    lx_pos = p + 17'd1;
            end
        end
    endfunction

    // Predict on each input transfer, check each result transfer
    always @(posedge i_clk) begin
        t_token_rec want;
        t_stim_row  row;
        if (!i_rst_n) begin
            lex_reset();
        end else begin
            if (i_in_valid && o_in_ready) begin
                lex_transfer(i_kind, i_text_byte);
                if (pin_rows.size() != 0) begin
                    row = pin_rows.pop_front();
                    if (row.pin != PIN_NONE) begin
                        if (row.pin == PIN_EOF)
                            want = '{TT_EOF, row.pin_val[15:0], '0, '0, '0, 1'b0};
                        else
                            want = '{TT_ERROR, '0, '0, '0, row.pin_val, 1'b0};
                        if (step_tokens.size() == 0)
                            step_tokens.push_back(want);
                        else
                            step_tokens[step_tokens.size()-1] = want;
                    end
                end
                if (step_tokens.size() != 0)
                    step_tokens[step_tokens.size()-1].last = 1'b1;
                foreach (step_tokens[k])
                    expected_tokens.push_back(step_tokens[k]);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("token record with none expected: type %0d start %0d",
                           o_token_type, o_start_pos);
                    fail_count++;
                end else begin
                    want = expected_tokens.pop_front();
                    tokens_checked++;
                    if (o_token_type !== want.tok) begin
                        $error("token_type: expected %0d, got %0d", want.tok, o_token_type);
                        fail_count++;
                    end
                    if (o_start_pos !== want.start) begin
                        $error("start_pos: expected %0d, got %0d", want.start, o_start_pos);
                        fail_count++;
                    end
                    if (o_raw_length !== want.raw) begin
                        $error("raw_length: expected %0d, got %0d", want.raw, o_raw_length);
                        fail_count++;
                    end
                    if (o_value_length !== want.value) begin
                        $error("value_length: expected %0d, got %0d",
                               want.value, o_value_length);
                        fail_count++;
                    end
                    if (o_error_pos !== want.epos) begin
                        $error("error_pos: expected %0d, got %0d", want.epos, o_error_pos);
                        fail_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, o_last);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Offer one item and hold it until the transfer
    task automatic send_item(input logic kind, input logic [7:0] ch);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_text_byte <= ch;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(IT_BYTE, s[i]);
    endtask

    task automatic send_end();
        send_item(IT_END, 8'($urandom_range(255)));
    endtask

    // Drop valid and wait until every predicted record has come out
    task automatic drain_tokens();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_tokens.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] byte_except(logic [7:0] a, logic [7:0] b);
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (c == a || c == b);
        return c;
    endfunction

    function automatic logic [7:0] rand_alnum(bit letters_only);
        int n;
        n = letters_only ? $urandom_range(51) : $urandom_range(61);
        if (n < 26)
            return 8'("a" + n);
        else if (n < 52)
            return 8'("A" + n - 26);
        else
            return 8'("0" + n - 52);
    endfunction

    // One well-formed token or separator with random content
    task automatic send_fragment();
        int sel;
        sel = $urandom_range(99);
        if (sel < 20) begin
            if ($urandom_range(3) == 0) begin
                case ($urandom_range(3))
                    0: send_text("section");
                    1: send_text("sect");
                    2: send_text("sections");
                    default: send_text("Section");
                endcase
            end else begin
                send_item(IT_BYTE, rand_alnum(1'b1));
                repeat ($urandom_range(5)) send_item(IT_BYTE, rand_alnum(1'b0));
            end
        end else if (sel < 35) begin
            send_item(IT_BYTE, CH_QUOTE);
            repeat ($urandom_range(6)) begin
                if ($urandom_range(4) == 0) begin
                    send_item(IT_BYTE, CH_BSLASH);
                    send_item(IT_BYTE, $urandom_range(1) ? CH_BSLASH : CH_QUOTE);
                end else begin
                    send_item(IT_BYTE, byte_except(CH_QUOTE, CH_BSLASH));
                end
            end
            send_item(IT_BYTE, CH_QUOTE);
        end else if (sel < 50) begin
            if ($urandom_range(3) == 0) begin
                send_item(IT_BYTE, CH_ZERO);
            end else begin
                if ($urandom_range(1))
                    send_item(IT_BYTE, CH_MINUS);
                send_item(IT_BYTE, 8'("0" + $urandom_range(1, 9)));
                repeat ($urandom_range(4)) send_item(IT_BYTE, 8'("0" + $urandom_range(9)));
            end
        end else if (sel < 70) begin
            case ($urandom_range(3))
                0: send_item(IT_BYTE, CH_LBRACE);
                1: send_item(IT_BYTE, CH_RBRACE);
                2: send_item(IT_BYTE, CH_EQUALS);
                default: send_item(IT_BYTE, CH_SEMI);
            endcase
        end else if (sel < 88) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(3))
                    0: send_item(IT_BYTE, CH_SPACE);
                    1: send_item(IT_BYTE, CH_TAB);
                    2: send_item(IT_BYTE, CH_CR);
                    default: send_item(IT_BYTE, CH_LF);
                endcase
            end
        end else begin
            send_item(IT_BYTE, CH_HASH);
            repeat ($urandom_range(6)) send_item(IT_BYTE, byte_except(CH_CR, CH_LF));
            send_item(IT_BYTE, $urandom_range(1) ? CH_CR : CH_LF);
        end
    endtask

    // One config text: mostly well formed, sometimes noisy or cut short
    task automatic send_random_text();
        int n;
        n = $urandom_range(1, 10);
        repeat (n) send_fragment();
        if ($urandom_range(99) < 20) begin
            case ($urandom_range(5))
                0: send_item(IT_BYTE, 8'($urandom_range(255)));
                1: begin
                    send_item(IT_BYTE, CH_QUOTE);
                    repeat ($urandom_range(3)) send_item(IT_BYTE, rand_alnum(1'b0));
                end
                2: begin
                    send_item(IT_BYTE, CH_QUOTE);
                    send_item(IT_BYTE, CH_BSLASH);
                    if ($urandom_range(1))
                        send_item(IT_BYTE, byte_except(CH_BSLASH, CH_QUOTE));
                end
                3: send_item(IT_BYTE, CH_MINUS);
                4: begin
                    send_item(IT_BYTE, CH_MINUS);
                    send_item(IT_BYTE, $urandom_range(1) ? CH_ZERO : rand_alnum(1'b1));
                end
                default: begin
                    send_item(IT_BYTE, $urandom_range(1) ? 8'($urandom_range(8))
                                                         : 8'($urandom_range(128, 255)));
                    repeat (2) send_fragment();
                end
            endcase
        end
        send_end();
    endtask

    // Main sequence
    initial begin
        int tx_mix [4];
        int rx_mix [4];
        int target;
        tx_mix = '{0, 63, 0, 16};
        rx_mix = '{0, 0, 63, 16};
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_kind         = IT_BYTE;
        i_text_byte    = '0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        hold_pending   = 1'b0;
        fail_count     = 0;
        live_items     = 0;
        tokens_checked = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (dir_rows[i]) begin
            pin_rows.push_back(dir_rows[i]);
            send_item(dir_rows[i].kind, dir_rows[i].ch);
        end
        drain_tokens();

        // Hold the result side off while the sender keeps offering tokens
        hold_pending = 1'b1;
        repeat (30) send_item(IT_BYTE, CH_LBRACE);
        send_end();
        drain_tokens();

        // Random config text under each idle and stall mix
        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct  = tx_mix[ph];
            rx_stall_pct = rx_mix[ph];
            target = live_items + PHASE_ITEMS;
            while (live_items < target)
                send_random_text();
            drain_tokens();
        end

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Lexed %0d live transfers and matched %0d token records,", live_items,
                 tokens_checked);
        $display("incl. broken tokens, idle and stall mixes and a full-queue input stall.");
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
rtl/ctlex_pkg.sv
rtl/ctlex_front.sv
rtl/ctlex_queue.sv
rtl/ctlex_back.sv
rtl/config_text_lexer_top.sv
sim/tb_top.sv
